// ===== sv/cpdp_pkg.sv =====
// Shared types, register codes and saturating helpers for the point projection pipeline.
`default_nettype none
package cpdp_pkg;

	// Input point and projected result
	typedef struct packed {
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic signed [31:0] point_z;
	} point_t;

	typedef struct packed {
		logic signed [31:0] pixel_x;
		logic signed [31:0] pixel_y;
		logic [1:0]         status;
	} result_t;

	// Register indexes
	localparam logic [2:0] REG_FOCAL_X = 3'd0;
	localparam logic [2:0] REG_FOCAL_Y = 3'd1;
	localparam logic [2:0] REG_PP      = 3'd2;
	localparam logic [2:0] REG_K1      = 3'd3;
	localparam logic [2:0] REG_K2      = 3'd4;
	localparam logic [2:0] REG_K3      = 3'd5;
	localparam logic [2:0] REG_P1      = 3'd6;
	localparam logic [2:0] REG_P2      = 3'd7;

	// Status codes
	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_ZERO = 2'd1;
	localparam logic [1:0] ST_SAT  = 2'd2;

	// Fixed-point shifts: Q32.32 times Q32.32, Q8.24 times Q32.32
	localparam int unsigned SH_Q32 = 32;
	localparam int unsigned SH_Q24 = 24;

	// Divider steps and tail stages; accept-to-strobe latency in cycles
	localparam int unsigned DIV_STEPS = 64;
	localparam int unsigned TAIL_STAGES = 31;
	localparam int unsigned LATENCY = DIV_STEPS + TAIL_STAGES + 1;

	localparam logic signed [63:0] INT64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [63:0] INT64_MIN = 64'sh8000_0000_0000_0000;
	localparam logic signed [63:0] ONE_Q32   = 64'sh0000_0001_0000_0000;

	// Sign and magnitude to signed 64, saturating; returns {sat, value}
	function automatic logic [64:0] frommag(input logic neg, input logic [63:0] m);
		logic ovf;
		if (neg) begin
			ovf = m[63] && (|m[62:0]);
			return {ovf, ovf ? INT64_MIN : 64'(64'd0 - m)};
		end else begin
			ovf = m[63];
			return {ovf, ovf ? INT64_MAX : m};
		end
	endfunction

	// Saturating signed add; returns {sat, value}
	function automatic logic [64:0] sadd(input logic signed [63:0] a,
		input logic signed [63:0] b);
		logic [64:0] s;
		s = {a[63], a} + {b[63], b};
		if (s[64] != s[63]) begin
			return {1'b1, s[64] ? INT64_MIN : INT64_MAX};
		end
		return {1'b0, s[63:0]};
	endfunction

	// Clamp to signed 32; returns {sat, value}
	function automatic logic [32:0] clamp32(input logic signed [63:0] v);
		if (!v[63] && (|v[62:31])) begin
			return {1'b1, 32'h7FFF_FFFF};
		end
		if (v[63] && !(&v[62:31])) begin
			return {1'b1, 32'h8000_0000};
		end
		return {1'b0, v[31:0]};
	endfunction

endpackage
`default_nettype wire

// ===== sv/cpdp_smul.sv =====
// Four-stage saturating signed 64x64 multiplier with a fixed right shift.
`default_nettype none
module cpdp_smul #(
	parameter int unsigned SHIFT = cpdp_pkg::SH_Q32
) (
	input  logic               clk,
	input  logic signed [63:0] a,
	input  logic signed [63:0] b,
	output logic signed [63:0] p,
	output logic               sat
);
	import cpdp_pkg::*;

	logic [63:0]  ma_s1, mb_s1;
	logic         neg_s1, neg_s2, neg_s3;
	logic [63:0]  p00_s2, p01_s2, p10_s2, p11_s2;
	logic [127:0] prod_s3;
	logic         ovf;
	logic [63:0]  mag;
	logic [64:0]  fm;

	// magnitude, shift and saturate
	assign ovf = |prod_s3[127:64+SHIFT];
	assign mag = ovf ? '1 : prod_s3[63+SHIFT:SHIFT];
	assign fm  = frommag(neg_s3, mag);

	always_ff @(posedge clk) begin
		// s1: magnitudes
		ma_s1  <= a[63] ? 64'(-a) : 64'(a);
		mb_s1  <= b[63] ? 64'(-b) : 64'(b);
		neg_s1 <= a[63] ^ b[63];
		// s2: partial products
		p00_s2 <= 64'(ma_s1[31:0])  * 64'(mb_s1[31:0]);
		p01_s2 <= 64'(ma_s1[31:0])  * 64'(mb_s1[63:32]);
		p10_s2 <= 64'(ma_s1[63:32]) * 64'(mb_s1[31:0]);
		p11_s2 <= 64'(ma_s1[63:32]) * 64'(mb_s1[63:32]);
		neg_s2 <= neg_s1;
		// s3: full product
		prod_s3 <= {p11_s2, p00_s2} + {32'b0, p01_s2, 32'b0} + {32'b0, p10_s2, 32'b0};
		neg_s3  <= neg_s2;
		// s4: result
		p   <= fm[63:0];
		sat <= ovf | fm[64];
	end

endmodule
`default_nettype wire

// ===== sv/camera_point_distortion_projection.sv =====
// Top level: pinhole projection with radial-tangential lens distortion, fully pipelined.
`default_nettype none
// One camera-space point (Q16.16) enters on each cycle in which start is high;
// busy never rises, so a new point may follow in every cycle. Each point comes
// out on result with a one-cycle done strobe, in order. The latency is set by
// the 64-stage restoring divider that forms x/z and y/z (one quotient bit per
// stage) followed by the 31-stage distortion and scaling tail, where each
// 64-bit product takes four stages. Results cannot be held off. Configure the
// registers only while no point is in flight.
module camera_point_distortion_projection (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  cpdp_pkg::point_t  point,
	input  logic              cfg_wr,
	input  logic [2:0]        cfg_addr,
	input  logic [63:0]       cfg_data,
	output logic              done,
	output cpdp_pkg::result_t result
);
	import cpdp_pkg::*;

	localparam int unsigned LAST = LATENCY - 1;

	// Configuration
	logic [31:0] fx_q, fy_q, k1_q, k2_q, k3_q, p1_q, p2_q;
	logic [63:0] pp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fx_q <= 32'd65536;
			fy_q <= 32'd65536;
			pp_q <= '0;
			k1_q <= '0;
			k2_q <= '0;
			k3_q <= '0;
			p1_q <= '0;
			p2_q <= '0;
		end else if (cfg_wr) begin
			unique case (cfg_addr)
				REG_FOCAL_X: fx_q <= cfg_data[31:0];
				REG_FOCAL_Y: fy_q <= cfg_data[31:0];
				REG_PP:      pp_q <= cfg_data;
				REG_K1:      k1_q <= cfg_data[31:0];
				REG_K2:      k2_q <= cfg_data[31:0];
				REG_K3:      k3_q <= cfg_data[31:0];
				REG_P1:      p1_q <= cfg_data[31:0];
				REG_P2:      p2_q <= cfg_data[31:0];
			endcase
		end
	end

	logic signed [63:0] k1, k2, k3, p1, p2, cx, cy, fx, fy;
	assign k1 = {{32{k1_q[31]}}, k1_q};
	assign k2 = {{32{k2_q[31]}}, k2_q};
	assign k3 = {{32{k3_q[31]}}, k3_q};
	assign p1 = {{32{p1_q[31]}}, p1_q};
	assign p2 = {{32{p2_q[31]}}, p2_q};
	assign cx = {{32{pp_q[31]}}, pp_q[31:0]};
	assign cy = {{32{pp_q[63]}}, pp_q[63:32]};
	assign fx = {32'b0, fx_q};
	assign fy = {32'b0, fy_q};

	assign busy = 1'b0;

	// Valid and zero-depth flags travel with the item
	logic vld_s [0:LAST];
	logic zero_s [0:LAST-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j <= LAST; j++) vld_s[j] <= 1'b0;
		end else begin
			vld_s[0] <= start & ~busy;
			for (int j = 1; j <= LAST; j++) vld_s[j] <= vld_s[j-1];
		end
	end

	always_ff @(posedge clk) begin
		zero_s[0] <= (point.point_z == 32'sd0);
		for (int j = 1; j < LAST; j++) zero_s[j] <= zero_s[j-1];
	end

	// Restoring divider: (|p| << 32) / |z|, one quotient bit per stage
	function automatic logic [31:0] mag32(input logic [31:0] v);
		return v[31] ? 32'(32'd0 - v) : v;
	endfunction

	function automatic logic [95:0] dstep(input logic [31:0] r, input logic [63:0] n,
		input logic [31:0] d);
		logic [32:0] t;
		logic        ge;
		t  = {r, n[63]};
		ge = t >= {1'b0, d};
		return {ge ? 32'(t - {1'b0, d}) : t[31:0], n[62:0], ge};
	endfunction

	logic [31:0] rx_s [0:DIV_STEPS-1];
	logic [31:0] ry_s [0:DIV_STEPS-1];
	logic [63:0] nx_s [0:DIV_STEPS];
	logic [63:0] ny_s [0:DIV_STEPS];
	logic [31:0] mz_s [0:DIV_STEPS-1];
	logic        sgx_s [0:DIV_STEPS];
	logic        sgy_s [0:DIV_STEPS];
	logic [95:0] stx [0:DIV_STEPS-1];
	logic [95:0] sty [0:DIV_STEPS-1];

	always_comb begin
		for (int j = 0; j < DIV_STEPS; j++) begin
			stx[j] = dstep(rx_s[j], nx_s[j], mz_s[j]);
			sty[j] = dstep(ry_s[j], ny_s[j], mz_s[j]);
		end
	end

	always_ff @(posedge clk) begin
		rx_s[0]  <= '0;
		ry_s[0]  <= '0;
		nx_s[0]  <= {mag32(point.point_x), 32'b0};
		ny_s[0]  <= {mag32(point.point_y), 32'b0};
		mz_s[0]  <= mag32(point.point_z);
		sgx_s[0] <= point.point_x[31] ^ point.point_z[31];
		sgy_s[0] <= point.point_y[31] ^ point.point_z[31];
		for (int j = 1; j <= DIV_STEPS; j++) begin
			nx_s[j]  <= stx[j-1][63:0];
			ny_s[j]  <= sty[j-1][63:0];
			sgx_s[j] <= sgx_s[j-1];
			sgy_s[j] <= sgy_s[j-1];
		end
		for (int j = 1; j < DIV_STEPS; j++) begin
			rx_s[j] <= stx[j-1][95:64];
			ry_s[j] <= sty[j-1][95:64];
			mz_s[j] <= mz_s[j-1];
		end
	end

	// Tail stage values (stage numbers count from the quotient register)
	logic signed [63:0] xp_s [1:19];
	logic signed [63:0] yp_s [1:19];
	logic signed [63:0] r2_s [6:10];
	logic signed [63:0] xx2_s6, yy2_s6, tx_s7, ty_s7;
	logic signed [63:0] ttx_s [10:23];
	logic signed [63:0] tty_s [10:23];
	logic signed [63:0] p2tx_s [12:24];
	logic signed [63:0] p1ty_s [12:24];
	logic signed [63:0] rad1_s [11:14];
	logic signed [63:0] rad2_s [15:18];
	logic signed [63:0] rad_s19;
	logic signed [63:0] xd1_s24, yd1_s24, xd2_s25, yd2_s25;
	logic signed [63:0] ox1_s30, oy1_s30;

	// Multiplier outputs
	logic signed [63:0] xx_s5, yy_s5, xy_s5, p1xy_s9, p2xy_s9, r4_s10, k1r2_s10;
	logic signed [63:0] p2tx_s11, p1ty_s11, r6_s14, k2r4_s14, k3r6_s18;
	logic signed [63:0] xd0_s23, yd0_s23, ox0_s29, oy0_s29;
	logic m_xx, m_yy, m_xy, m_p1xy, m_p2xy, m_r4, m_k1r2, m_p2tx, m_p1ty;
	logic m_r6, m_k2r4, m_k3r6, m_xd, m_yd, m_ox, m_oy;

	cpdp_smul #(.SHIFT(SH_Q32)) u_xx   (.clk, .a(xp_s[1]), .b(xp_s[1]), .p(xx_s5), .sat(m_xx));
	cpdp_smul #(.SHIFT(SH_Q32)) u_yy   (.clk, .a(yp_s[1]), .b(yp_s[1]), .p(yy_s5), .sat(m_yy));
	cpdp_smul #(.SHIFT(SH_Q32)) u_xy   (.clk, .a(xp_s[1]), .b(yp_s[1]), .p(xy_s5), .sat(m_xy));
	cpdp_smul #(.SHIFT(SH_Q24)) u_p1xy (.clk, .a(p1), .b(xy_s5), .p(p1xy_s9), .sat(m_p1xy));
	cpdp_smul #(.SHIFT(SH_Q24)) u_p2xy (.clk, .a(p2), .b(xy_s5), .p(p2xy_s9), .sat(m_p2xy));
	cpdp_smul #(.SHIFT(SH_Q32)) u_r4   (.clk, .a(r2_s[6]), .b(r2_s[6]), .p(r4_s10), .sat(m_r4));
	cpdp_smul #(.SHIFT(SH_Q24)) u_k1r2 (.clk, .a(k1), .b(r2_s[6]), .p(k1r2_s10), .sat(m_k1r2));
	cpdp_smul #(.SHIFT(SH_Q24)) u_p2tx (.clk, .a(p2), .b(tx_s7), .p(p2tx_s11), .sat(m_p2tx));
	cpdp_smul #(.SHIFT(SH_Q24)) u_p1ty (.clk, .a(p1), .b(ty_s7), .p(p1ty_s11), .sat(m_p1ty));
	cpdp_smul #(.SHIFT(SH_Q32)) u_r6   (.clk, .a(r4_s10), .b(r2_s[10]), .p(r6_s14), .sat(m_r6));
	cpdp_smul #(.SHIFT(SH_Q24)) u_k2r4 (.clk, .a(k2), .b(r4_s10), .p(k2r4_s14), .sat(m_k2r4));
	cpdp_smul #(.SHIFT(SH_Q24)) u_k3r6 (.clk, .a(k3), .b(r6_s14), .p(k3r6_s18), .sat(m_k3r6));
	cpdp_smul #(.SHIFT(SH_Q32)) u_xd   (.clk, .a(xp_s[19]), .b(rad_s19), .p(xd0_s23), .sat(m_xd));
	cpdp_smul #(.SHIFT(SH_Q32)) u_yd   (.clk, .a(yp_s[19]), .b(rad_s19), .p(yd0_s23), .sat(m_yd));
	cpdp_smul #(.SHIFT(SH_Q32)) u_ox   (.clk, .a(fx), .b(xd2_s25), .p(ox0_s29), .sat(m_ox));
	cpdp_smul #(.SHIFT(SH_Q32)) u_oy   (.clk, .a(fy), .b(yd2_s25), .p(oy0_s29), .sat(m_oy));

	// Quotients and saturating sums, in the order the formula needs them
	logic [64:0] xp_w, yp_w, r2_w, xx2_w, yy2_w, tx_w, ty_w, ttx_w, tty_w;
	logic [64:0] rad1_w, rad2_w, rad_w, xd1_w, yd1_w, xd2_w, yd2_w, ox1_w, oy1_w;

	assign xp_w   = frommag(sgx_s[DIV_STEPS], nx_s[DIV_STEPS]);
	assign yp_w   = frommag(sgy_s[DIV_STEPS], ny_s[DIV_STEPS]);
	assign r2_w   = sadd(xx_s5, yy_s5);
	assign xx2_w  = sadd(xx_s5, xx_s5);
	assign yy2_w  = sadd(yy_s5, yy_s5);
	assign tx_w   = sadd(r2_s[6], xx2_s6);
	assign ty_w   = sadd(r2_s[6], yy2_s6);
	assign ttx_w  = sadd(p1xy_s9, p1xy_s9);
	assign tty_w  = sadd(p2xy_s9, p2xy_s9);
	assign rad1_w = sadd(ONE_Q32, k1r2_s10);
	assign rad2_w = sadd(rad1_s[14], k2r4_s14);
	assign rad_w  = sadd(rad2_s[18], k3r6_s18);
	assign xd1_w  = sadd(xd0_s23, ttx_s[23]);
	assign yd1_w  = sadd(yd0_s23, tty_s[23]);
	assign xd2_w  = sadd(xd1_s24, p2tx_s[24]);
	assign yd2_w  = sadd(yd1_s24, p1ty_s[24]);
	assign ox1_w  = sadd(ox0_s29, cx);
	assign oy1_w  = sadd(oy0_s29, cy);

	always_ff @(posedge clk) begin
		xp_s[1] <= xp_w[63:0];
		yp_s[1] <= yp_w[63:0];
		for (int k = 2; k <= 19; k++) begin
			xp_s[k] <= xp_s[k-1];
			yp_s[k] <= yp_s[k-1];
		end
		r2_s[6] <= r2_w[63:0];
		for (int k = 7; k <= 10; k++) r2_s[k] <= r2_s[k-1];
		xx2_s6 <= xx2_w[63:0];
		yy2_s6 <= yy2_w[63:0];
		tx_s7  <= tx_w[63:0];
		ty_s7  <= ty_w[63:0];
		ttx_s[10] <= ttx_w[63:0];
		tty_s[10] <= tty_w[63:0];
		for (int k = 11; k <= 23; k++) begin
			ttx_s[k] <= ttx_s[k-1];
			tty_s[k] <= tty_s[k-1];
		end
		p2tx_s[12] <= p2tx_s11;
		p1ty_s[12] <= p1ty_s11;
		for (int k = 13; k <= 24; k++) begin
			p2tx_s[k] <= p2tx_s[k-1];
			p1ty_s[k] <= p1ty_s[k-1];
		end
		rad1_s[11] <= rad1_w[63:0];
		for (int k = 12; k <= 14; k++) rad1_s[k] <= rad1_s[k-1];
		rad2_s[15] <= rad2_w[63:0];
		for (int k = 16; k <= 18; k++) rad2_s[k] <= rad2_s[k-1];
		rad_s19 <= rad_w[63:0];
		xd1_s24 <= xd1_w[63:0];
		yd1_s24 <= yd1_w[63:0];
		xd2_s25 <= xd2_w[63:0];
		yd2_s25 <= yd2_w[63:0];
		ox1_s30 <= ox1_w[63:0];
		oy1_s30 <= oy1_w[63:0];
	end

	// Sticky saturation flag: products seen at their stage, sums as they register
	logic [29:1] ev_mul;
	logic [30:1] ev_add;
	logic        satc [1:30];

	always_comb begin
		ev_mul = '0;
		ev_add = '0;
		ev_mul[5]  = m_xx | m_yy | m_xy;
		ev_mul[9]  = m_p1xy | m_p2xy;
		ev_mul[10] = m_r4 | m_k1r2;
		ev_mul[11] = m_p2tx | m_p1ty;
		ev_mul[14] = m_r6 | m_k2r4;
		ev_mul[18] = m_k3r6;
		ev_mul[23] = m_xd | m_yd;
		ev_mul[29] = m_ox | m_oy;
		ev_add[1]  = xp_w[64] | yp_w[64];
		ev_add[6]  = r2_w[64] | xx2_w[64] | yy2_w[64];
		ev_add[7]  = tx_w[64] | ty_w[64];
		ev_add[10] = ttx_w[64] | tty_w[64];
		ev_add[11] = rad1_w[64];
		ev_add[15] = rad2_w[64];
		ev_add[19] = rad_w[64];
		ev_add[24] = xd1_w[64] | yd1_w[64];
		ev_add[25] = xd2_w[64] | yd2_w[64];
		ev_add[30] = ox1_w[64] | oy1_w[64];
	end

	always_ff @(posedge clk) begin
		satc[1] <= ev_add[1];
		for (int k = 2; k <= 30; k++) satc[k] <= satc[k-1] | ev_mul[k-1] | ev_add[k];
	end

	// Final clamp and status
	logic [32:0] cpx, cpy;
	result_t     res_s31;

	assign cpx = clamp32(ox1_s30);
	assign cpy = clamp32(oy1_s30);

	always_ff @(posedge clk) begin
		if (zero_s[LAST-1]) begin
			res_s31.pixel_x <= '0;
			res_s31.pixel_y <= '0;
			res_s31.status  <= ST_ZERO;
		end else begin
			res_s31.pixel_x <= cpx[31:0];
			res_s31.pixel_y <= cpy[31:0];
			res_s31.status  <= (satc[30] | cpx[32] | cpy[32]) ? ST_SAT : ST_OK;
		end
	end

	assign done   = vld_s[LAST];
	assign result = res_s31;

endmodule
`default_nettype wire

// ===== sv/cpdp_checker.sv =====
// Port-level checks for the projection pipeline, bound to the top level.
`default_nettype none
module cpdp_checker (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              start,
	input wire logic              busy,
	input wire cpdp_pkg::result_t result,
	input wire logic              done
);
	import cpdp_pkg::*;

	// every accepted item shows up after the fixed latency
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LATENCY done)
		else $error("item not delivered after pipeline latency");

	// a strobe needs an item accepted that many cycles earlier
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("result strobe without an accepted item");

	// zero depth yields a zero pixel
	a_zero_out: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status == ST_ZERO) |-> (result.pixel_x == 0 && result.pixel_y == 0))
		else $error("zero-depth result not cleared");

	// only defined status codes
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.status == ST_OK || result.status == ST_ZERO ||
			result.status == ST_SAT))
		else $error("undefined status code");

endmodule

bind camera_point_distortion_projection cpdp_checker u_cpdp_checker (
	.clk(clk),
	.arst_n(arst_n),
	.start(start),
	.busy(busy),
	.result(result),
	.done(done)
);
`default_nettype wire
